/* hdl/adn_pkg.sv */
// ----------------------------------------------------------------------------
// adn_pkg
// Shared types and constants for the approximate distance normalize core.
// ----------------------------------------------------------------------------
package adn_pkg;

    localparam int unsigned SCALE_W = 16;
    localparam int unsigned QUOT_W  = 16;
    localparam int unsigned DIR_W   = 17;
    localparam int unsigned LEN_W   = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

    typedef struct packed {
        logic             neg_x;
        logic             neg_y;
        logic             zero;
        logic [LEN_W-1:0] len;
    } t_meta;

endpackage

/* hdl/adn_prep.sv */
// ----------------------------------------------------------------------------
// adn_prep
// Front end: magnitudes, octagonal length, divisor and scaled dividends.
// ----------------------------------------------------------------------------
module adn_prep #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [COORD_WIDTH-1:0]                i_x,
    input  logic [COORD_WIDTH-1:0]                i_y,
    input  logic [adn_pkg::SCALE_W-1:0]           i_scale,
    output logic [COORD_WIDTH+adn_pkg::SCALE_W-1:0] o_num_x,
    output logic [COORD_WIDTH+adn_pkg::SCALE_W-1:0] o_num_y,
    output logic [COORD_WIDTH:0]                  o_den,
    output adn_pkg::t_meta                        o_meta
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + adn_pkg::SCALE_W;

    logic [W-1:0]  r_ax, r_ay, n_ax, n_ay, r_m, n_m;
    logic          r_nx, r_ny;
    logic [W:0]    n_len;
    logic [NW-1:0] r_num_x, r_num_y;
    logic [W:0]    r_den;
    adn_pkg::t_meta r_meta;

    always_comb begin
        n_ax = i_x[W-1] ? (~i_x + 1'b1) : i_x;
        n_ay = i_y[W-1] ? (~i_y + 1'b1) : i_y;
        n_m  = (n_ax < n_ay) ? n_ax : n_ay;
    end

    always_comb begin
        n_len = {1'b0, r_ax} + {1'b0, r_ay} - {2'b0, r_m[W-1:1]}
              - {3'b0, r_m[W-1:2]} + {5'b0, r_m[W-1:4]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_m  <= n_m;
            r_nx <= i_x[W-1];
            r_ny <= i_y[W-1];
            r_num_x     <= NW'(r_ax) * NW'(i_scale);
            r_num_y     <= NW'(r_ay) * NW'(i_scale);
            r_den       <= (n_len == '0) ? (W+1)'(1) : n_len;
            r_meta.neg_x <= r_nx;
            r_meta.neg_y <= r_ny;
            r_meta.zero  <= (n_len == '0);
            r_meta.len   <= adn_pkg::LEN_W'(n_len);
        end
    end

    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den;
    assign o_meta  = r_meta;
endmodule

/* hdl/adn_div_lane.sv */
// ----------------------------------------------------------------------------
// adn_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module adn_div_lane #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [COORD_WIDTH+adn_pkg::SCALE_W-1:0] i_num,
    input  logic [COORD_WIDTH:0]                    i_den,
    output logic [adn_pkg::QUOT_W-1:0]              o_quot
);
    localparam int NW = COORD_WIDTH + adn_pkg::SCALE_W;
    localparam int DW = COORD_WIDTH + 1;
    localparam int QW = adn_pkg::QUOT_W;

    logic [NW-1:0] r_rem [1:QW];
    logic [DW-1:0] r_den [1:QW];
    logic [QW-1:0] r_q   [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [NW-1:0] n_sub;
        logic          n_ge;
        if (k == 0) begin : g_head
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_body
            assign rem_in = r_rem[k];
            assign den_in = r_den[k];
            assign q_in   = r_q[k];
        end
        always_comb begin
            n_sub = NW'(den_in) << (QW-1-k);
            n_ge  = (rem_in >= n_sub);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? (rem_in - n_sub) : rem_in;
                r_den[k+1] <= den_in;
                r_q[k+1]   <= q_in | (QW'(n_ge) << (QW-1-k));
            end
        end
    end

    assign o_quot = r_q[QW];
endmodule

/* hdl/approx_distance_normalize_core.sv */
// ----------------------------------------------------------------------------
// approx_distance_normalize_core
// Octagonal length approximation and scaled vector normalize, two divider
// lanes (x, y) merged into one result register.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// request   in   i_valid / o_stall  i_x_coord, i_y_coord
// result    out  o_valid / i_stall  o_dir_x, o_dir_y, o_length, o_zero_length
// config    in   i_scale_we         i_scale
//
// One request per cycle while o_stall is low; 2 front end stages, 16 divider
// stages and 1 output register. The divider pipeline makes up most of the depth.
// Reset is synchronous, active low; clears valids, scale returns to 1000.
// A stalled valid result freezes the whole pipeline and o_stall rises.
// ----------------------------------------------------------------------------
module approx_distance_normalize_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [COORD_WIDTH-1:0]            i_x_coord,
    input  logic [COORD_WIDTH-1:0]            i_y_coord,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [adn_pkg::DIR_W-1:0]  o_dir_x,
    output logic signed [adn_pkg::DIR_W-1:0]  o_dir_y,
    output logic [adn_pkg::LEN_W-1:0]         o_length,
    output logic                              o_zero_length,
    input  logic                              i_scale_we,
    input  logic [adn_pkg::SCALE_W-1:0]       i_scale
);
    localparam int NW = COORD_WIDTH + adn_pkg::SCALE_W;
    localparam int QW = adn_pkg::QUOT_W;
    localparam int DW = adn_pkg::DIR_W;

    logic                        adv;
    logic [adn_pkg::SCALE_W-1:0] r_scale;
    logic                        r_v1, r_v2, r_out_vld;
    logic [QW-1:0]               r_vd;
    adn_pkg::t_meta              r_meta [0:QW-1];
    logic [NW-1:0]               num_x, num_y;
    logic [COORD_WIDTH:0]        den;
    adn_pkg::t_meta              meta;
    logic [QW-1:0]               q_x, q_y;
    logic [DW-1:0]               r_dx, r_dy;
    logic [adn_pkg::LEN_W-1:0]   r_len;
    logic                        r_zero;

    assign adv     = !(r_out_vld && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= adn_pkg::SCALE_RESET;
        end else if (i_scale_we) begin
            r_scale <= i_scale;
        end
    end

    adn_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .i_scale (r_scale),
        .o_num_x (num_x),
        .o_num_y (num_y),
        .o_den   (den),
        .o_meta  (meta)
    );

    adn_div_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .i_clk (i_clk), .i_en (adv), .i_num (num_x), .i_den (den), .o_quot (q_x)
    );

    adn_div_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .i_clk (i_clk), .i_en (adv), .i_num (num_y), .i_den (den), .o_quot (q_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_vd      <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_v1      <= i_valid;
            r_v2      <= r_v1;
            r_vd      <= {r_vd[QW-2:0], r_v2};
            r_out_vld <= r_vd[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_meta[0] <= meta;
            for (int k = 1; k < QW; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
            // merge lanes: apply signs
            r_dx   <= r_meta[QW-1].neg_x ? (DW'(0) - DW'(q_x)) : DW'(q_x);
            r_dy   <= r_meta[QW-1].neg_y ? (DW'(0) - DW'(q_y)) : DW'(q_y);
            r_len  <= r_meta[QW-1].len;
            r_zero <= r_meta[QW-1].zero;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_dir_x       = r_dx;
    assign o_dir_y       = r_dy;
    assign o_length      = r_len;
    assign o_zero_length = r_zero;
endmodule

/* hdl/adn_checker.sv */
// ----------------------------------------------------------------------------
// adn_checker
// Port-level checks for approx_distance_normalize_core.
// ----------------------------------------------------------------------------
module adn_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [adn_pkg::DIR_W-1:0]  o_dir_x,
    input logic signed [adn_pkg::DIR_W-1:0]  o_dir_y,
    input logic [adn_pkg::LEN_W-1:0]         o_length,
    input logic                              o_zero_length
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_dir_x) && $stable(o_dir_y) && $stable(o_length))
        else $error("stalled result changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without a blocked result");

    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_dir_x == '0 && o_dir_y == '0 && o_length == '0)
        else $error("zero length with nonzero fields");
endmodule

bind approx_distance_normalize_core adn_checker u_adn_checker (.*);

/* sim/approx_distance_normalize_core_test.sv */
// ----------------------------------------------------------------------------
// approx_distance_normalize_core_test
// Self-checking bench for the octagonal length / vector normalize core: a
// table of directed requests, then random vectors over several scale values
// and idle/stall phases; every result is checked against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module approx_distance_normalize_core_test;

    localparam int CW        = 32;
    localparam int N_RANDOM  = 1750;
    localparam int LATENCY   = 19;
    localparam int MAX_CYC   = 400000;

    typedef struct packed {
        logic [adn_pkg::DIR_W-1:0] dir_x;
        logic [adn_pkg::DIR_W-1:0] dir_y;
        logic [adn_pkg::LEN_W-1:0] length;
        logic                      zero_length;
    } t_norm;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        bit            known;
        t_norm         res;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    logic [CW-1:0]                    i_x_coord;
    logic [CW-1:0]                    i_y_coord;
    logic                             o_valid;
    logic                             i_stall;
    logic signed [adn_pkg::DIR_W-1:0] o_dir_x;
    logic signed [adn_pkg::DIR_W-1:0] o_dir_y;
    logic [adn_pkg::LEN_W-1:0]        o_length;
    logic                             o_zero_length;
    logic                             i_scale_we;
    logic [adn_pkg::SCALE_W-1:0]      i_scale;

    approx_distance_normalize_core #(.COORD_WIDTH(CW)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_length      (o_length),
        .o_zero_length (o_zero_length),
        .i_scale_we    (i_scale_we),
        .i_scale       (i_scale)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    logic [adn_pkg::SCALE_W-1:0] scale_model;
    t_norm              expected_q[$];
    int                 errors   = 0;
    int                 results  = 0;
    int                 requests = 0;
    int                 cycles   = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    bit                 hold_off = 0;

    function automatic t_norm normalize(logic [CW-1:0] x, logic [CW-1:0] y,
                                        logic [adn_pkg::SCALE_W-1:0] sc);
        t_norm   r;
        bit      nx, ny;
        logic [63:0] ax, ay, m, len, div, qx, qy;
        nx  = x[CW-1];
        ny  = y[CW-1];
        ax  = nx ? 64'((~x) + 1'b1) : 64'(x);
        ay  = ny ? 64'((~y) + 1'b1) : 64'(y);
        ax  = ax & ((64'd1 << CW) - 1);
        ay  = ay & ((64'd1 << CW) - 1);
        m   = (ax < ay) ? ax : ay;
        len = ax + ay - (m >> 1) - (m >> 2) + (m >> 4);
        div = (len == 0) ? 64'd1 : len;
        qx  = (ax * sc) / div;
        qy  = (ay * sc) / div;
        if (nx) qx = 64'd0 - qx;
        if (ny) qy = 64'd0 - qy;
        r.dir_x       = qx[adn_pkg::DIR_W-1:0];
        r.dir_y       = qy[adn_pkg::DIR_W-1:0];
        r.length      = len[adn_pkg::LEN_W-1:0];
        r.zero_length = (len == 0);
        return r;
    endfunction

    // receiver side
    always @(negedge i_clk) begin
        if (hold_off)
            i_stall <= 1'b1;
        else
            i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_norm e;
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("%0t timeout", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results <= results + 1;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h %h %h %b", $time,
                         o_dir_x, o_dir_y, o_length, o_zero_length);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_dir_x !== e.dir_x || o_dir_y !== e.dir_y ||
                    o_length !== e.length || o_zero_length !== e.zero_length) begin
                    $display("%0t mismatch exp %0d %0d %h %b got %0d %0d %h %b",
                             $time, $signed(e.dir_x), $signed(e.dir_y), e.length,
                             e.zero_length, o_dir_x, o_dir_y, o_length, o_zero_length);
                    errors++;
                end
            end
        end
    end

    // offers one request, returns after acceptance
    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y,
                               bit known, t_norm fixed);
        t_norm p;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        p = normalize(x, y, scale_model);
        if (known && p != fixed) begin
            $display("%0t predictor disagrees with table for %h %h", $time, x, y);
            errors++;
        end
        expected_q.push_back(known ? fixed : p);
        requests++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_scale(logic [adn_pkg::SCALE_W-1:0] v);
        drain();
        i_scale_we <= 1'b1;
        i_scale    <= v;
        @(negedge i_clk);
        i_scale_we <= 1'b0;
        scale_model = v;
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return CW'($signed($urandom_range(2000)) - 1000);
            2: return {1'b1, {(CW-1){1'b0}}} | CW'($urandom_range(3));
            3: return {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(3));
            4: return CW'($urandom()) >>> $urandom_range(31);
            default: return 0;
        endcase
    endfunction

    function automatic t_norm mk(int dx, int dy, logic [31:0] len, bit z);
        t_norm r;
        r.dir_x       = adn_pkg::DIR_W'(dx);
        r.dir_y       = adn_pkg::DIR_W'(dy);
        r.length      = len;
        r.zero_length = z;
        return r;
    endfunction

    t_row table_rows[$];

    initial begin
        t_norm nul;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_x_coord  = '0;
        i_y_coord  = '0;
        i_scale_we = 1'b0;
        i_scale    = '0;
        scale_model = adn_pkg::SCALE_RESET;
        nul = mk(0, 0, 0, 0);

        table_rows.push_back('{32'd0, 32'd0, 1, mk(0, 0, 0, 1)});
        table_rows.push_back('{32'd1, 32'd0, 1, mk(1000, 0, 1, 0)});
        table_rows.push_back('{32'd0, -32'sd1, 1, mk(0, -1000, 1, 0)});
        table_rows.push_back('{32'd100, 32'd0, 1, mk(1000, 0, 100, 0)});
        table_rows.push_back('{32'h7fffffff, 32'd0, 1, mk(1000, 0, 32'h7fffffff, 0)});
        table_rows.push_back('{32'h80000000, 32'd0, 1, mk(-1000, 0, 32'h80000000, 0)});
        table_rows.push_back('{32'd0, 32'h80000000, 1, mk(0, -1000, 32'h80000000, 0)});
        table_rows.push_back('{32'h80000000, 32'h80000000, 0, nul});
        table_rows.push_back('{32'h7fffffff, 32'h7fffffff, 0, nul});
        table_rows.push_back('{32'h80000000, 32'h7fffffff, 0, nul});
        table_rows.push_back('{32'd3, 32'd4, 0, nul});
        table_rows.push_back('{-32'sd3, 32'd4, 0, nul});
        table_rows.push_back('{32'd16, -32'sd16, 0, nul});
        table_rows.push_back('{32'hffffffff, 32'hffffffff, 0, nul});
        table_rows.push_back('{32'h55555555, 32'haaaaaaaa, 0, nul});
        table_rows.push_back('{32'haaaaaaaa, 32'h55555555, 0, nul});

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (table_rows[k])
            send_vector(table_rows[k].x, table_rows[k].y, table_rows[k].known,
                        table_rows[k].res);

        set_scale(16'hffff);
        send_vector(32'h80000000, 32'd0, 1, mk(-65535, 0, 32'h80000000, 0));
        send_vector(32'd5, 32'd0, 1, mk(65535, 0, 5, 0));
        send_vector(32'd0, 32'd0, 1, mk(0, 0, 0, 1));
        set_scale(16'd1);
        send_vector(32'd7, -32'sd7, 0, nul);
        send_vector(32'd0, 32'h7fffffff, 1, mk(0, 1, 32'h7fffffff, 0));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  set_scale(adn_pkg::SCALE_RESET); end
                1: begin idle_pct = 50; stall_pct = 0;  set_scale(16'hffff); end
                2: begin idle_pct = 0;  stall_pct = 50; set_scale(16'd1); end
                3: begin
                    idle_pct = 25; stall_pct = 25;
                    set_scale(adn_pkg::SCALE_W'($urandom_range(65535, 1)));
                end
                default: begin
                    idle_pct = 0; stall_pct = 0;
                    set_scale(adn_pkg::SCALE_W'($urandom_range(65535, 1)));
                end
            endcase
            if (ph == 4) begin
                hold_off = 1;
                fork
                    begin
                        repeat (200) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 5; n++)
                send_vector(rand_coord(), rand_coord(), 0, nul);
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        $display("Covered %0d requests and %0d results over scales 1..65535,",
                 requests, results);
        $display("with extremes, zero vectors, idle/stall phases and a long hold-off.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* files.f */
hdl/adn_pkg.sv
hdl/adn_prep.sv
hdl/adn_div_lane.sv
hdl/approx_distance_normalize_core.sv
hdl/adn_checker.sv
sim/approx_distance_normalize_core_test.sv
